// ===== rtl/brb_pkg.sv =====
// Shared types, constants and helpers for the byte ring buffer.
package brb_pkg;

  // Ring geometry and the per-request read limit.
  localparam int DEPTH    = 1024;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int MAX_READ = 64;
  localparam int RIDX_W   = $clog2(MAX_READ + 1);

  // Request kinds carried in the kind field.
  localparam logic [2:0] KIND_ENQUEUE    = 3'd0;
  localparam logic [2:0] KIND_DEQUEUE    = 3'd1;
  localparam logic [2:0] KIND_PEEK       = 3'd2;
  localparam logic [2:0] KIND_MOVE_FRONT = 3'd3;
  localparam logic [2:0] KIND_MOVE_REAR  = 3'd4;
  localparam logic [2:0] KIND_CLEAR      = 3'd5;

  // One input transaction.
  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] length;
    logic [7:0] data_in;
    logic       final_byte;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  data_out;
    logic        data_valid;
    logic [9:0]  granted;
    logic [9:0]  used_count;
    logic [9:0]  free_count;
    logic [10:0] contig_write;
    logic [9:0]  contig_read;
    logic        last;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_RD_ISSUE,
    ST_RD_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic execute;
    logic rd_issue;
    logic out_load_status;
    logic out_load_data;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_go;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

  // Ring index advance with wrap at DEPTH; n is below DEPTH.
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [PTR_W-1:0] n);
    logic [PTR_W:0] sum;
    sum = {1'b0, ptr} + {1'b0, n};
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = sum - (PTR_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/byte_ring_buffer.sv =====
// Byte ring buffer: 1024-slot byte FIFO with enqueue, dequeue, peek, move and clear requests.
// A single-result request executes, then its result is registered once the output is free.
// Dequeue and peek read bytes one at a time (one storage read port, registered read).
// Requests are handled one at a time; the next is accepted the cycle after its last result
// is loaded into the output register.
// Reset clears pointers, counts and any open enqueue; storage contents stay undefined.
module byte_ring_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  brb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output brb_pkg::out_item_t out_data
);

  brb_pkg::ctl_cmd_t cmd;
  brb_pkg::dp_stat_t stat;

  // Sequencer.
  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, pointers and result register.
  brb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/brb_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  brb_pkg::dp_stat_t stat,
  output brb_pkg::ctl_cmd_t cmd
);

  brb_pkg::state_t state_r;
  brb_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = brb_pkg::ST_EXEC;
        end
      end
      brb_pkg::ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = stat.read_go ? brb_pkg::ST_RD_ISSUE : brb_pkg::ST_RESP;
      end
      brb_pkg::ST_RESP: begin
        if (stat.out_free) begin
          cmd.out_load_status = 1'b1;
          state_nxt           = brb_pkg::ST_IDLE;
        end
      end
      brb_pkg::ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = brb_pkg::ST_RD_OUT;
      end
      brb_pkg::ST_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_load_data = 1'b1;
          state_nxt = stat.rd_last ? brb_pkg::ST_IDLE : brb_pkg::ST_RD_ISSUE;
        end
      end
      default: begin
        state_nxt = brb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/brb_datapath.sv =====
// Datapath: byte storage, ring pointers, request bookkeeping and result register.
module brb_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  brb_pkg::in_item_t  in_data,
  input  brb_pkg::ctl_cmd_t  cmd,
  output brb_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output brb_pkg::out_item_t out_data
);

  localparam int PW = brb_pkg::PTR_W;
  localparam int RW = brb_pkg::RIDX_W;

  // Byte storage, contents undefined until written.
  logic [7:0] mem [brb_pkg::DEPTH];
  logic [7:0] rd_data_r;

  brb_pkg::in_item_t item_r;

  logic [PW-1:0] front_r, front_nxt;
  logic [PW-1:0] rear_r, rear_nxt;
  logic [PW-1:0] used_r, used_nxt;
  logic          wr_active_r, wr_active_nxt;
  logic          wr_accepted_r, wr_accepted_nxt;
  logic [PW-1:0] wr_offset_r, wr_offset_nxt;
  logic [PW-1:0] n_r, n_nxt;
  logic [PW-1:0] rd_base_r;
  logic [RW-1:0] rd_idx_r;
  logic          out_valid_r;
  brb_pkg::out_item_t out_data_r;

  logic [PW-1:0] len;
  logic [PW-1:0] free_w;
  logic          acc_eff;
  logic [PW-1:0] off_eff;
  logic          store;
  logic [PW-1:0] off_new;
  logic [PW-1:0] avail;
  logic          read_kind;
  logic [PW-1:0] rd_addr;
  logic [PW:0]   room_rear;
  logic [PW:0]   room_front;
  logic [PW:0]   cw;
  logic [PW-1:0] cr;

  assign len    = PW'(item_r.length);
  assign free_w = PW'(brb_pkg::DEPTH - 1) - used_r;

  // Enqueue request tracking: open on the first byte, count stored bytes.
  assign acc_eff = wr_active_r ? wr_accepted_r : (len <= free_w);
  assign off_eff = wr_active_r ? wr_offset_r : '0;
  assign store   = acc_eff && (off_eff < len) && (off_eff < free_w);
  assign off_new = off_eff + PW'(store);

  // Bytes available for a read, clamped to the read limit.
  always_comb begin
    avail = (used_r < len) ? used_r : len;
    if (avail > PW'(brb_pkg::MAX_READ)) begin
      avail = PW'(brb_pkg::MAX_READ);
    end
  end

  assign read_kind = (item_r.kind == brb_pkg::KIND_DEQUEUE) ||
                     (item_r.kind == brb_pkg::KIND_PEEK);

  // Per-kind update of pointers and request state.
  always_comb begin
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    used_nxt        = used_r;
    wr_active_nxt   = wr_active_r;
    wr_accepted_nxt = wr_accepted_r;
    wr_offset_nxt   = wr_offset_r;
    n_nxt           = '0;
    case (item_r.kind)
      brb_pkg::KIND_ENQUEUE: begin
        if (item_r.final_byte) begin
          n_nxt           = acc_eff ? ((off_new < free_w) ? off_new : free_w) : '0;
          rear_nxt        = brb_pkg::ptr_add(rear_r, n_nxt);
          used_nxt        = used_r + n_nxt;
          wr_active_nxt   = 1'b0;
          wr_accepted_nxt = 1'b0;
          wr_offset_nxt   = '0;
        end else begin
          n_nxt           = acc_eff ? off_new : '0;
          wr_active_nxt   = 1'b1;
          wr_accepted_nxt = acc_eff;
          wr_offset_nxt   = off_new;
        end
      end
      brb_pkg::KIND_DEQUEUE: begin
        n_nxt     = avail;
        front_nxt = brb_pkg::ptr_add(front_r, avail);
        used_nxt  = used_r - avail;
      end
      brb_pkg::KIND_PEEK: begin
        n_nxt = avail;
      end
      brb_pkg::KIND_MOVE_FRONT: begin
        n_nxt     = (len < used_r) ? len : used_r;
        front_nxt = brb_pkg::ptr_add(front_r, n_nxt);
        used_nxt  = used_r - n_nxt;
      end
      brb_pkg::KIND_MOVE_REAR: begin
        n_nxt    = (len < free_w) ? len : free_w;
        rear_nxt = brb_pkg::ptr_add(rear_r, n_nxt);
        used_nxt = used_r + n_nxt;
      end
      brb_pkg::KIND_CLEAR: begin
        front_nxt       = '0;
        rear_nxt        = '0;
        used_nxt        = '0;
        wr_active_nxt   = 1'b0;
        wr_accepted_nxt = 1'b0;
        wr_offset_nxt   = '0;
      end
      default: begin
        n_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r       <= '0;
      rear_r        <= '0;
      used_r        <= '0;
      wr_active_r   <= 1'b0;
      wr_accepted_r <= 1'b0;
      wr_offset_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.execute) begin
        front_r       <= front_nxt;
        rear_r        <= rear_nxt;
        used_r        <= used_nxt;
        wr_active_r   <= wr_active_nxt;
        wr_accepted_r <= wr_accepted_nxt;
        wr_offset_r   <= wr_offset_nxt;
      end
      if (cmd.out_load_status || cmd.out_load_data) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture, grant count and read sequencing.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r <= in_data;
    end
    if (cmd.execute) begin
      n_r       <= n_nxt;
      rd_base_r <= front_r;
      rd_idx_r  <= '0;
    end else if (cmd.out_load_data) begin
      rd_idx_r  <= rd_idx_r + RW'(1);
    end
  end

  // Storage write for enqueue bytes and registered read.
  assign rd_addr = brb_pkg::ptr_add(rd_base_r, PW'(rd_idx_r));

  always_ff @(posedge clk) begin
    if (cmd.execute && (item_r.kind == brb_pkg::KIND_ENQUEUE) && store) begin
      mem[brb_pkg::ptr_add(rear_r, off_eff)] <= item_r.data_in;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Size report from the current pointers.
  assign room_rear  = (PW + 1)'(brb_pkg::DEPTH) - {1'b0, rear_r};
  assign room_front = (PW + 1)'(brb_pkg::DEPTH) - {1'b0, front_r};
  assign cw = ({1'b0, free_w} < room_rear) ? {1'b0, free_w} : room_rear;
  assign cr = ({1'b0, used_r} < room_front) ? used_r : room_front[PW-1:0];

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load_status || cmd.out_load_data) begin
      out_data_r.data_out     <= cmd.out_load_data ? rd_data_r : 8'd0;
      out_data_r.data_valid   <= cmd.out_load_data;
      out_data_r.granted      <= 10'(n_r);
      out_data_r.used_count   <= 10'(used_r);
      out_data_r.free_count   <= 10'(free_w);
      out_data_r.contig_write <= 11'(cw);
      out_data_r.contig_read  <= 10'(cr);
      out_data_r.last         <= cmd.out_load_status || stat.rd_last;
    end
  end

  // Status back to the controller.
  assign stat.read_go  = read_kind && (n_nxt != '0);
  assign stat.rd_last  = ((PW + 1)'(rd_idx_r) + (PW + 1)'(1)) == {1'b0, n_r};
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/brb_checker.sv =====
// Checker for the byte ring buffer: predicts results from accepted transactions and compares them.
module brb_checker
  import brb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        open_results
);

  localparam int unsigned RING = DEPTH;

  // Predicted ring contents and pointers.
  logic [7:0]  ring_mem [RING];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  int unsigned fill     = 0;

  // State of the enqueue request that is still open, if any.
  bit          req_open = 1'b0;
  bit          req_ok   = 1'b0;
  int unsigned req_off  = 0;

  // Results still owed by the block, oldest first.
  out_item_t   due_results [$];
  int          mismatches = 0;

  function automatic int unsigned smaller(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned room();
    return RING - 1 - fill;
  endfunction

  // Build a result with the sizes as they stand after the request.
  function automatic out_item_t status_word(input logic [7:0] byte_val, input logic valid,
                                            input int unsigned grant, input logic tail_flag);
    out_item_t r;
    r.data_out     = byte_val;
    r.data_valid   = valid;
    r.granted      = 10'(grant);
    r.used_count   = 10'(fill);
    r.free_count   = 10'(room());
    r.contig_write = 11'(smaller(room(), RING - tail_idx));
    r.contig_read  = 10'(smaller(fill, RING - head_idx));
    r.last         = tail_flag;
    return r;
  endfunction

  // Advance the predicted state by one request and queue the results it owes.
  task automatic apply_request(input in_item_t req);
    int unsigned n;
    logic [7:0]  got [MAX_READ];
    case (req.kind)
      KIND_ENQUEUE: begin
        if (!req_open) begin
          req_open = 1'b1;
          req_ok   = (req.length <= room());
          req_off  = 0;
        end
        if (req_ok && req_off < req.length && req_off < room()) begin
          ring_mem[(tail_idx + req_off) % RING] = req.data_in;
          req_off++;
        end
        if (req.final_byte) begin
          // Commit: the rear moves by what was stored and still fits.
          n        = req_ok ? smaller(req_off, room()) : 0;
          tail_idx = (tail_idx + n) % RING;
          fill     = fill + n;
          req_open = 1'b0;
          req_ok   = 1'b0;
          req_off  = 0;
        end else begin
          n = req_ok ? req_off : 0;
        end
        due_results.push_back(status_word(8'h00, 1'b0, n, 1'b1));
      end
      KIND_DEQUEUE, KIND_PEEK: begin
        n = smaller(smaller(fill, req.length), MAX_READ);
        for (int i = 0; i < n; i++) begin
          got[i] = ring_mem[(head_idx + i) % RING];
        end
        if (req.kind == KIND_DEQUEUE) begin
          head_idx = (head_idx + n) % RING;
          fill     = fill - n;
        end
        if (n == 0) begin
          due_results.push_back(status_word(8'h00, 1'b0, 0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            due_results.push_back(status_word(got[i], 1'b1, n, (i + 1 == n)));
          end
        end
      end
      KIND_MOVE_FRONT: begin
        n        = smaller(req.length, fill);
        head_idx = (head_idx + n) % RING;
        fill     = fill - n;
        due_results.push_back(status_word(8'h00, 1'b0, n, 1'b1));
      end
      KIND_MOVE_REAR: begin
        n        = smaller(req.length, room());
        tail_idx = (tail_idx + n) % RING;
        fill     = fill + n;
        due_results.push_back(status_word(8'h00, 1'b0, n, 1'b1));
      end
      KIND_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
        fill     = 0;
        req_open = 1'b0;
        req_ok   = 1'b0;
        req_off  = 0;
        due_results.push_back(status_word(8'h00, 1'b0, 0, 1'b1));
      end
      default: begin
        due_results.push_back(status_word(8'h00, 1'b0, 0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction, then fold in the request accepted at this edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      head_idx = 0;
      tail_idx = 0;
      fill     = 0;
      req_open = 1'b0;
      req_ok   = 1'b0;
      req_off  = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result transaction arrived with none expected");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("data_out", want.data_out, out_data.data_out);
          check_field("data_valid", want.data_valid, out_data.data_valid);
          check_field("granted", want.granted, out_data.granted);
          check_field("used_count", want.used_count, out_data.used_count);
          check_field("free_count", want.free_count, out_data.free_count);
          check_field("contig_write", want.contig_write, out_data.contig_write);
          check_field("contig_read", want.contig_read, out_data.contig_read);
          check_field("last", want.last, out_data.last);
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_data);
      end
    end
    open_results   <= due_results.size();
    mismatch_count <= mismatches;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the byte ring buffer regression: clock, reset, stimulus, handshake pressure and verdict.
module testbench;
  import brb_pkg::*;

  // Kind codes that the block does not define.
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int send_gap_pct;
  int recv_stall_pct;
  int sent_items;
  int quiet_cycles;
  int mismatch_total;
  int open_results;
  int kind_tally [8];

  byte_ring_buffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  brb_checker ring_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_total),
    .open_results  (open_results)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Count cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a hung block ends the run.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("byte_ring_buffer regression: fail");
    $finish;
  end

  // Offer one request transaction, starting and ending at a falling edge.
  task automatic send_item(input logic [2:0] kind, input logic [9:0] len,
                           input logic [7:0] byte_val, input logic final_flag);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, length: len, data_in: byte_val, final_byte: final_flag};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    kind_tally[kind]++;
    sent_items++;
    @(negedge clk);
  endtask

  // Lengths spread over small values, the read limit and the full field.
  function automatic logic [9:0] pick_length();
    case ($urandom_range(3))
      0:       return 10'($urandom_range(0, 8));
      1:       return 10'($urandom_range(0, 80));
      2:       return 10'($urandom);
      default: return 10'($urandom_range(1000, 1023));
    endcase
  endfunction

  // A well-formed enqueue request, optionally interrupted halfway by another request.
  task automatic send_enqueue(input int unsigned len, input int unsigned count,
                              input bit interrupt);
    for (int k = 0; k < count; k++) begin
      send_item(KIND_ENQUEUE, 10'(len), 8'($urandom), k == count - 1);
      if (interrupt && k == count / 2 && k != count - 1) begin
        send_item(3'($urandom_range(KIND_DEQUEUE, KIND_CLEAR)), pick_length(),
                  8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Random traffic until the item count reaches the goal.
  task automatic run_phase(input int goal);
    int pick;
    int unsigned len;
    while (sent_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = ($urandom_range(29) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
        send_enqueue(len, len, $urandom_range(4) == 0);
      end else if (pick < 55) begin
        send_item(KIND_DEQUEUE, pick_length(), 8'($urandom), 1'($urandom));
      end else if (pick < 65) begin
        send_item(KIND_PEEK, pick_length(), 8'($urandom), 1'($urandom));
      end else if (pick < 72) begin
        send_item(KIND_MOVE_FRONT, pick_length(), 8'($urandom), 1'($urandom));
      end else if (pick < 79) begin
        send_item(KIND_MOVE_REAR, pick_length(), 8'($urandom), 1'($urandom));
      end else if (pick < 91) begin
        // Malformed enqueue traffic.
        case ($urandom_range(3))
          0: send_enqueue($urandom_range(1023), $urandom_range(1, 6), 1'b0);
          1: send_enqueue($urandom_range(0, 10), $urandom_range(1, 14), 1'b0);
          2: begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
              send_item(KIND_ENQUEUE, pick_length(), 8'($urandom), k == len - 1);
            end
          end
          default: begin
            // Left open; later traffic either continues or drops it.
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
              send_item(KIND_ENQUEUE, 10'($urandom_range(1, 12)), 8'($urandom), 1'b0);
            end
          end
        endcase
      end else if (pick < 96) begin
        send_item(KIND_CLEAR, pick_length(), 8'($urandom), 1'($urandom));
      end else begin
        send_item(($urandom_range(1) == 0) ? KIND_SPARE_A : KIND_SPARE_B, pick_length(),
                  8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Main sequence.
  initial begin
    int base;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_gap_pct   = 6;
    recv_stall_pct = 71;
    sent_items     = 0;
    foreach (kind_tally[i]) kind_tally[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the ring to capacity in one request; this writes every slot but the last.
    for (int k = 0; k < DEPTH - 1; k++) begin
      send_item(KIND_ENQUEUE, 10'(DEPTH - 1), 8'($urandom), k == DEPTH - 2);
    end
    // Full ring: a refused enqueue, a move of the rear that clamps to nothing, long reads.
    send_item(KIND_ENQUEUE, 10'd1, 8'hFF, 1'b1);
    send_item(KIND_MOVE_REAR, 10'd1023, 8'h00, 1'b0);
    send_item(KIND_PEEK, 10'd1023, 8'h00, 1'b0);
    send_item(KIND_DEQUEUE, 10'(MAX_READ), 8'hFF, 1'b1);
    // Write the last slot so the rear wraps; from here no slot is unwritten.
    send_item(KIND_ENQUEUE, 10'd1, 8'h00, 1'b1);
    // Move of the front that clamps to the used count, then reads of an empty ring.
    send_item(KIND_MOVE_FRONT, 10'd1023, 8'hFF, 1'b1);
    send_item(KIND_DEQUEUE, 10'd5, 8'h00, 1'b0);
    send_item(KIND_PEEK, 10'd0, 8'h00, 1'b0);
    send_item(KIND_SPARE_A, 10'd1023, 8'hFF, 1'b1);
    send_item(KIND_SPARE_B, 10'd0, 8'h00, 1'b0);
    // A zero-length request, and one with more bytes than its length.
    send_item(KIND_ENQUEUE, 10'd0, 8'hA5, 1'b1);
    send_enqueue(3, 5, 1'b0);
    // Another request between the bytes of an open enqueue.
    send_item(KIND_ENQUEUE, 10'd2, 8'h5A, 1'b0);
    send_item(KIND_DEQUEUE, 10'd1, 8'h00, 1'b0);
    send_item(KIND_ENQUEUE, 10'd2, 8'hC3, 1'b1);
    // Rear moved to the clamp, then a refused enqueue on the full ring.
    send_item(KIND_MOVE_REAR, 10'd1023, 8'h00, 1'b1);
    send_item(KIND_ENQUEUE, 10'd1, 8'h3C, 1'b1);
    send_item(KIND_MOVE_FRONT, 10'd100, 8'h00, 1'b0);
    send_item(KIND_PEEK, 10'd3, 8'h00, 1'b0);
    send_item(KIND_CLEAR, 10'd0, 8'h00, 1'b0);
    // Clear drops an open request.
    send_item(KIND_ENQUEUE, 10'd4, 8'h11, 1'b0);
    send_item(KIND_CLEAR, 10'd1023, 8'hFF, 1'b1);
    send_item(KIND_ENQUEUE, 10'd1, 8'h22, 1'b1);

    // Random traffic under three pressure mixes.
    base = sent_items;
    run_phase(base + RANDOM_ITEMS / 3);
    send_gap_pct   = 71;
    recv_stall_pct = 6;
    run_phase(base + 2 * RANDOM_ITEMS / 3);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(base + RANDOM_ITEMS);
    in_valid <= 1'b0;

    // Drain the owed results, then give any stray result time to show up.
    while (open_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%s%s",
             $sformatf("Sent %0d transactions: %0d enqueue, %0d dequeue, %0d peek, ",
                       sent_items, kind_tally[KIND_ENQUEUE], kind_tally[KIND_DEQUEUE],
                       kind_tally[KIND_PEEK]),
             $sformatf("%0d move, %0d clear, %0d undefined.",
                       kind_tally[KIND_MOVE_FRONT] + kind_tally[KIND_MOVE_REAR],
                       kind_tally[KIND_CLEAR],
                       kind_tally[KIND_SPARE_A] + kind_tally[KIND_SPARE_B]));
    $display("The ring was filled to capacity and wrapped; traffic ran under three stall mixes.");
    if (mismatch_total == 0) begin
      $display("byte_ring_buffer regression: pass");
    end else begin
      $display("byte_ring_buffer regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/brb_pkg.sv
rtl/brb_ctrl.sv
rtl/brb_datapath.sv
rtl/byte_ring_buffer.sv
tb/sv/brb_checker.sv
tb/sv/testbench.sv
